@@ design/hsvrgb_pkg.sv @@
package hsvrgb_pkg;

   localparam logic [15:0] HUE_FULL   = 16'd23040;
   localparam logic [15:0] HUE_FULL_2 = 16'd46080;

   localparam logic [14:0] HUE_EDGE_1 = 15'd3840;
   localparam logic [14:0] HUE_EDGE_2 = 15'd7680;
   localparam logic [14:0] HUE_EDGE_3 = 15'd11520;
   localparam logic [14:0] HUE_EDGE_4 = 15'd15360;
   localparam logic [14:0] HUE_EDGE_5 = 15'd19200;
   localparam logic [14:0] HUE_EDGE_6 = 15'd23040;

   localparam logic [8:0] Q8_ONE = 9'd256;

   // floor(y / 15) = (y * 4370) >> 16 for y below 4681
   localparam logic [12:0] DIV15_RECIP = 13'd4370;

   typedef enum logic [2:0] {
      SECT_0,
      SECT_1,
      SECT_2,
      SECT_3,
      SECT_4,
      SECT_5
   } sector_type;

   typedef struct packed {
      logic       valid;
      sector_type sector;
   } pix_ctl_type;

endpackage

@@ design/hsvrgb_prep.sv @@
module hsvrgb_prep (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  logic [15:0]              hue,
   input  logic [8:0]               saturation,
   input  logic [8:0]               brightness,
   output hsvrgb_pkg::pix_ctl_type  ctl_out,
   output logic [11:0]              frac_out,
   output logic [8:0]               sat_out,
   output logic [15:0]              vm_out,
   output logic [23:0]              span_out
);
   import hsvrgb_pkg::*;

   // stage 1: hue reduction, clamps, value times 255
   logic        valid1_ff;
   logic [14:0] hue1_ff, hue1_in;
   logic [8:0]  sat1_ff, sat1_in;
   logic [15:0] vm1_ff, vm1_in;
   logic [8:0]  bri_cl;

   // stage 2: sector, fraction, value times one less saturation (the min span)
   logic        valid2_ff;
   sector_type  sector2_ff, sector2_in;
   logic [11:0] frac2_ff, frac2_in;
   logic [8:0]  sat2_ff;
   logic [15:0] vm2_ff;
   logic [23:0] span2_ff, span2_in;
   logic [14:0] frac_wide;
   logic [8:0]  sat_inv;
   logic [24:0] span_prod;

   always_comb begin
      if (hue >= HUE_FULL_2) begin
         hue1_in = 15'(hue - HUE_FULL_2);
      end else if (hue >= HUE_FULL) begin
         hue1_in = 15'(hue - HUE_FULL);
      end else begin
         hue1_in = hue[14:0];
      end
      sat1_in = (saturation > Q8_ONE) ? Q8_ONE : saturation;
      bri_cl  = (brightness > Q8_ONE) ? Q8_ONE : brightness;
      vm1_in  = 16'({bri_cl, 8'd0} - {8'd0, bri_cl});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (advance) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   always_comb begin
      priority if (hue1_ff <= HUE_EDGE_1) begin
         sector2_in = SECT_0;
         frac_wide  = hue1_ff;
      end else if (hue1_ff <= HUE_EDGE_2) begin
         sector2_in = SECT_1;
         frac_wide  = HUE_EDGE_2 - hue1_ff;
      end else if (hue1_ff <= HUE_EDGE_3) begin
         sector2_in = SECT_2;
         frac_wide  = hue1_ff - HUE_EDGE_2;
      end else if (hue1_ff <= HUE_EDGE_4) begin
         sector2_in = SECT_3;
         frac_wide  = HUE_EDGE_4 - hue1_ff;
      end else if (hue1_ff <= HUE_EDGE_5) begin
         sector2_in = SECT_4;
         frac_wide  = hue1_ff - HUE_EDGE_4;
      end else begin
         sector2_in = SECT_5;
         frac_wide  = HUE_EDGE_6 - hue1_ff;
      end
      frac2_in  = frac_wide[11:0];
      sat_inv   = Q8_ONE - sat1_ff;
      span_prod = 25'(vm1_ff) * 25'(sat_inv);
      span2_in  = span_prod[23:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hue1_ff    <= hue1_in;
         sat1_ff    <= sat1_in;
         vm1_ff     <= vm1_in;
         sector2_ff <= sector2_in;
         frac2_ff   <= frac2_in;
         sat2_ff    <= sat1_ff;
         vm2_ff     <= vm1_ff;
         span2_ff   <= span2_in;
      end
   end

   assign ctl_out.valid  = valid2_ff;
   assign ctl_out.sector = sector2_ff;
   assign frac_out       = frac2_ff;
   assign sat_out        = sat2_ff;
   assign vm_out         = vm2_ff;
   assign span_out       = span2_ff;

endmodule

@@ design/hsvrgb_mid.sv @@
module hsvrgb_mid (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  hsvrgb_pkg::pix_ctl_type  ctl_in,
   input  logic [11:0]              frac_in,
   input  logic [8:0]               sat_in,
   input  logic [15:0]              vm_in,
   input  logic [23:0]              span_in,
   output hsvrgb_pkg::pix_ctl_type  ctl_out,
   output logic [11:0]              quot_out,
   output logic [7:0]               max_out,
   output logic [7:0]               min_out
);
   import hsvrgb_pkg::*;

   // stage 3: fraction times saturation
   logic        valid3_ff;
   sector_type  sector3_ff;
   logic [19:0] fs3_ff, fs3_in;
   logic [20:0] fs_prod;
   logic [15:0] vm3_ff;
   logic [23:0] span3_ff;
   logic [7:0]  max3_ff, min3_ff;

   // stage 4: the two numerator terms
   logic        valid4_ff;
   sector_type  sector4_ff;
   logic [35:0] term4_ff, term4_in;
   logic [35:0] base4_ff, base4_in;
   logic [7:0]  max4_ff, min4_ff;

   // stage 5: sum, scaled down by 2^24
   logic        valid5_ff;
   sector_type  sector5_ff;
   logic [11:0] quot5_ff;
   logic [35:0] num_sum;
   logic [7:0]  max5_ff, min5_ff;

   always_comb begin
      fs_prod  = 21'(frac_in) * 21'(sat_in);
      fs3_in   = fs_prod[19:0];
      term4_in = 36'(fs3_ff) * 36'(vm3_ff);
      base4_in = ({12'd0, span3_ff} << 12) - ({12'd0, span3_ff} << 8);
      num_sum  = term4_ff + base4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
      end else if (advance) begin
         valid3_ff <= ctl_in.valid;
         valid4_ff <= valid3_ff;
         valid5_ff <= valid4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sector3_ff <= ctl_in.sector;
         fs3_ff     <= fs3_in;
         vm3_ff     <= vm_in;
         span3_ff   <= span_in;
         max3_ff    <= vm_in[15:8];
         min3_ff    <= span_in[23:16];
         sector4_ff <= sector3_ff;
         term4_ff   <= term4_in;
         base4_ff   <= base4_in;
         max4_ff    <= max3_ff;
         min4_ff    <= min3_ff;
         sector5_ff <= sector4_ff;
         quot5_ff   <= num_sum[35:24];
         max5_ff    <= max4_ff;
         min5_ff    <= min4_ff;
      end
   end

   assign ctl_out.valid  = valid5_ff;
   assign ctl_out.sector = sector5_ff;
   assign quot_out       = quot5_ff;
   assign max_out        = max5_ff;
   assign min_out        = min5_ff;

endmodule

@@ design/hsvrgb_out.sv @@
module hsvrgb_out (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  hsvrgb_pkg::pix_ctl_type  ctl_in,
   input  logic [11:0]              quot_in,
   input  logic [7:0]               max_in,
   input  logic [7:0]               min_in,
   output logic                     out_valid,
   output logic [7:0]               red,
   output logic [7:0]               green,
   output logic [7:0]               blue
);
   import hsvrgb_pkg::*;

   logic        valid6_ff;
   logic [7:0]  red_ff, red_in;
   logic [7:0]  green_ff, green_in;
   logic [7:0]  blue_ff, blue_in;
   logic [24:0] recip_prod;
   logic [7:0]  mid;

   always_comb begin
      // divide by 15 finishes the divide by 3840
      recip_prod = 25'(quot_in) * 25'(DIV15_RECIP);
      mid        = recip_prod[23:16];
      unique case (ctl_in.sector)
         SECT_0: begin
            red_in = max_in; green_in = mid;    blue_in = min_in;
         end
         SECT_1: begin
            red_in = mid;    green_in = max_in; blue_in = min_in;
         end
         SECT_2: begin
            red_in = min_in; green_in = max_in; blue_in = mid;
         end
         SECT_3: begin
            red_in = min_in; green_in = mid;    blue_in = max_in;
         end
         SECT_4: begin
            red_in = mid;    green_in = min_in; blue_in = max_in;
         end
         SECT_5: begin
            red_in = max_in; green_in = min_in; blue_in = mid;
         end
         default: begin
            red_in = max_in; green_in = min_in; blue_in = mid;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid6_ff <= 1'b0;
      end else if (advance) begin
         valid6_ff <= ctl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign out_valid = valid6_ff;
   assign red       = red_ff;
   assign green     = green_ff;
   assign blue      = blue_ff;

endmodule

@@ design/hsv_to_rgb_converter_top.sv @@
// HSV to RGB converter. Takes hue in 1/64 degree (reduced modulo 360 degrees),
// saturation and value in Q8 (256 is 1.0, larger values clamp to 256) and
// returns 8-bit red, green and blue, each the exact value truncated toward zero.
// One word is accepted per clock while req_stall is low. Its result passes
// through the six-stage pipeline, whose first stage registers the input and
// which holds the multiplier chain for the middle channel. rsp_stall freezes the
// whole pipeline while a result is waiting; req_stall is high only then.
module hsv_to_rgb_converter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_hue,
   input  logic [8:0]  req_saturation,
   input  logic [8:0]  req_brightness,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue
);
   import hsvrgb_pkg::*;

   logic        advance;
   pix_ctl_type ctl_prep;
   pix_ctl_type ctl_mid;
   logic [11:0] frac;
   logic [8:0]  sat;
   logic [15:0] vm;
   logic [23:0] span;
   logic [11:0] quot;
   logic [7:0]  max_chan;
   logic [7:0]  min_chan;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   hsvrgb_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_valid),
      .hue        (req_hue),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .ctl_out    (ctl_prep),
      .frac_out   (frac),
      .sat_out    (sat),
      .vm_out     (vm),
      .span_out   (span)
   );

   hsvrgb_mid u_mid (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .ctl_in   (ctl_prep),
      .frac_in  (frac),
      .sat_in   (sat),
      .vm_in    (vm),
      .span_in  (span),
      .ctl_out  (ctl_mid),
      .quot_out (quot),
      .max_out  (max_chan),
      .min_out  (min_chan)
   );

   hsvrgb_out u_out (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .ctl_in    (ctl_mid),
      .quot_in   (quot),
      .max_in    (max_chan),
      .min_in    (min_chan),
      .out_valid (rsp_valid),
      .red       (rsp_red),
      .green     (rsp_green),
      .blue      (rsp_blue)
   );

endmodule

@@ design/hsvrgb_checker.sv @@
module hsvrgb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_red,
   input logic [7:0]  rsp_green,
   input logic [7:0]  rsp_blue
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_red)
         && $stable(rsp_green) && $stable(rsp_blue))
      else $error("stalled result changed");

   // input is held back only by a waiting result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a waiting result");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // an accepted word shows up at the output when the output does not stall in between
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
         ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("result missing after pipeline latency");

endmodule

bind hsv_to_rgb_converter_top hsvrgb_checker u_hsvrgb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_red   (rsp_red),
   .rsp_green (rsp_green),
   .rsp_blue  (rsp_blue)
);
